FILE: src/indexed_shift_list_core_assert.svh
`ifndef INDEXED_SHIFT_LIST_CORE_ASSERT_SVH
`define INDEXED_SHIFT_LIST_CORE_ASSERT_SVH

// same-cycle check
`define ISL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list core check failed");

// next-cycle check
`define ISL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list core check failed");

`endif

FILE: src/isl_pkg.sv
`timescale 1ns / 1ps

package isl_pkg;

  localparam int CAPACITY_DEFAULT   = 64;
  localparam int WORD_WIDTH_DEFAULT = 64;
  localparam int CNT_MAX_W          = 11;

  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_POP    = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_PUT    = 3'd4;
  localparam logic [2:0] MODE_GET    = 3'd5;
  localparam logic [2:0] MODE_CLEAR  = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  position;
    logic [63:0] data_word;
  } isl_in_t;

  typedef struct packed {
    logic [63:0] read_word;
    logic [1:0]  status;
    logic [6:0]  count;
  } isl_out_t;

  typedef struct packed {
    logic                 en;
    logic [2:0]           mode;
    logic [CNT_MAX_W-1:0] pos;
    logic [CNT_MAX_W-1:0] count;
  } isl_cell_cmd_t;

endpackage

FILE: src/isl_cell.sv
`timescale 1ns / 1ps

module isl_cell #(
  parameter int INDEX      = 0,
  parameter int WORD_WIDTH = isl_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  isl_pkg::isl_cell_cmd_t  cmd,
  input  logic [WORD_WIDTH-1:0]   data,
  input  logic [WORD_WIDTH-1:0]   lower_word,
  input  logic [WORD_WIDTH-1:0]   upper_word,
  output logic [WORD_WIDTH-1:0]   word
);

  localparam logic [isl_pkg::CNT_MAX_W:0] IDX      = (isl_pkg::CNT_MAX_W + 1)'(INDEX);
  localparam logic [isl_pkg::CNT_MAX_W:0] IDX_PLUS = (isl_pkg::CNT_MAX_W + 1)'(INDEX + 1);

  logic [isl_pkg::CNT_MAX_W:0] pos_x;
  logic [isl_pkg::CNT_MAX_W:0] cnt_x;
  logic [WORD_WIDTH-1:0]       word_next;

  assign pos_x = {1'b0, cmd.pos};
  assign cnt_x = {1'b0, cmd.count};

  always_comb begin
    word_next = word;
    if (cmd.en) begin
      case (cmd.mode)
        isl_pkg::MODE_PUSH: begin
          if (IDX == cnt_x) word_next = data;
        end
        isl_pkg::MODE_INSERT: begin
          if (IDX == pos_x) word_next = data;
          else if (IDX > pos_x && IDX <= cnt_x) word_next = lower_word;
        end
        isl_pkg::MODE_REMOVE: begin
          if (IDX >= pos_x && IDX_PLUS < cnt_x) word_next = upper_word;
        end
        isl_pkg::MODE_PUT: begin
          if (IDX == pos_x) word_next = data;
        end
        default: begin
          word_next = word;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

FILE: src/indexed_shift_list_core.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY words held in a row of cells, one word per cell.
// A command word is taken at any clock edge with start high and busy low; busy is
// high only during reset and the cycle after it. Every command gives one response
// word, shown with done for exactly one cycle, in the cycle after it was taken; the
// receiver cannot stall it. All cells shift or load in parallel, so insert and
// remove cost the same as push: one command per cycle, sustained while busy is low.
// Faults (empty, index out of range, full) leave the list unchanged and return
// zero as read_word.
module indexed_shift_list_core #(
  parameter int CAPACITY   = isl_pkg::CAPACITY_DEFAULT,
  parameter int WORD_WIDTH = isl_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  isl_pkg::isl_in_t  request,
  output logic              done,
  output isl_pkg::isl_out_t response
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int MW    = isl_pkg::CNT_MAX_W;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  init;
  logic                  accept;
  logic                  full;
  logic [MW-1:0]         pos_x;
  logic [MW-1:0]         cnt_x;
  logic [MW-1:0]         rd_sel;
  logic                  rd_en;
  logic [1:0]            status_c;
  logic [WORD_WIDTH-1:0] rd_word;
  logic [WORD_WIDTH-1:0] data;
  logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
  isl_pkg::isl_cell_cmd_t cell_cmd;

  assign busy   = rst | init;
  assign accept = start & ~busy;
  assign full   = (count == CNT_W'(CAPACITY));
  assign pos_x  = MW'(request.position);
  assign cnt_x  = MW'(count);
  assign data   = request.data_word[WORD_WIDTH-1:0];

  always_comb begin
    status_c   = isl_pkg::ST_OK;
    count_next = count;
    rd_en      = 1'b0;
    rd_sel     = pos_x;
    case (request.mode)
      isl_pkg::MODE_PUSH: begin
        if (full) status_c = isl_pkg::ST_FULL;
        else count_next = count + 1'b1;
      end
      isl_pkg::MODE_POP: begin
        rd_sel = cnt_x - 1'b1;
        if (count == '0) status_c = isl_pkg::ST_EMPTY;
        else begin
          count_next = count - 1'b1;
          rd_en      = 1'b1;
        end
      end
      isl_pkg::MODE_INSERT: begin
        if (full) status_c = isl_pkg::ST_FULL;
        else if (pos_x > cnt_x) status_c = isl_pkg::ST_RANGE;
        else count_next = count + 1'b1;
      end
      isl_pkg::MODE_REMOVE: begin
        if (pos_x >= cnt_x) status_c = isl_pkg::ST_RANGE;
        else begin
          count_next = count - 1'b1;
          rd_en      = 1'b1;
        end
      end
      isl_pkg::MODE_PUT: begin
        if (pos_x >= cnt_x) status_c = isl_pkg::ST_RANGE;
      end
      isl_pkg::MODE_GET: begin
        if (pos_x >= cnt_x) status_c = isl_pkg::ST_RANGE;
        else rd_en = 1'b1;
      end
      isl_pkg::MODE_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  assign cell_cmd.en    = accept && (status_c == isl_pkg::ST_OK);
  assign cell_cmd.mode  = request.mode;
  assign cell_cmd.pos   = pos_x;
  assign cell_cmd.count = cnt_x;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] lower;
    logic [WORD_WIDTH-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_word[i+1];
    end
    isl_cell #(
      .INDEX      (i),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .data       (data),
      .lower_word (lower),
      .upper_word (upper),
      .word       (cell_word[i])
    );
  end

  // read select across the row
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rd_sel == MW'(i)) rd_word = rd_word | cell_word[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init  <= 1'b1;
      count <= '0;
      done  <= 1'b0;
    end else begin
      init <= 1'b0;
      done <= accept;
      if (accept) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      response.read_word <= rd_en ? 64'(rd_word) : 64'd0;
      response.status    <= status_c;
      response.count     <= 7'(count_next);
    end
  end

endmodule

FILE: src/isl_checker.sv
`timescale 1ns / 1ps

`include "indexed_shift_list_core_assert.svh"

module isl_checker #(
  parameter int CAPACITY = isl_pkg::CAPACITY_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input isl_pkg::isl_in_t  request,
  input logic              done,
  input isl_pkg::isl_out_t response
);

  `ISL_ASSERT_NEXT(a_done_follows_accept, start && !busy, done)
  `ISL_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done)
  `ISL_ASSERT_NOW(a_fault_reads_zero, done && response.status != isl_pkg::ST_OK,
    response.read_word == 64'd0)
  `ISL_ASSERT_NOW(a_count_bounded, done, 32'(response.count) <= CAPACITY)
  `ISL_ASSERT_NOW(a_clear_empties, done && $past(request.mode) == isl_pkg::MODE_CLEAR,
    response.count == 7'd0 && response.status == isl_pkg::ST_OK)

endmodule

bind indexed_shift_list_core isl_checker #(
  .CAPACITY (CAPACITY)
) u_isl_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .request  (request),
  .done     (done),
  .response (response)
);
